// File: design/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg: shared types and constants for the trilinear voxel splat core
// Operation codes, widths of the shared multiplier and the saturating add.
// ----------------------------------------------------------------------------
package tvs_pkg;

	// default cube side
	localparam int GRID_SIZE_DEF = 8;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 12;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// voxel word: three 8-bit channels
	localparam int VOXEL_W = 24;

	// corner weights at or below 0.001 in 2^-24 units are dropped
	localparam logic [MUL_A_W-1:0] WEIGHT_FLOOR = 25'd16777;

	// request operation codes
	typedef enum logic [1:0] {
		OP_SPLAT = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// round (level * weight) from 2^-28 units, add to channel, clamp at 255
	function automatic logic [7:0] sat_add(input logic [7:0] cur,
		input logic [MUL_P_W-1:0] prod);
		logic [10:0] rnd;
		logic [9:0]  sum;
		rnd = {1'b0, prod[36:27]} + 11'd1;
		sum = {2'b00, cur} + rnd[10:1];
		return (sum > 10'd255) ? 8'hFF : sum[7:0];
	endfunction

endpackage

// File: design/tvs_ram.sv
// ----------------------------------------------------------------------------
// tvs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tvs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// storage array with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/tvs_mul.sv
// ----------------------------------------------------------------------------
// tvs_mul: shared multiplier of the splat sequencer
// One 25 x 12 unsigned multiply per cycle while en is high, product registered.
// ----------------------------------------------------------------------------
module tvs_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tvs_pkg::MUL_A_W-1:0] a,
	input  logic [tvs_pkg::MUL_B_W-1:0] b,
	output logic [tvs_pkg::MUL_P_W-1:0] prod
);

	logic [tvs_pkg::MUL_P_W-1:0] prod_q;

	// product register
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {{tvs_pkg::MUL_B_W{1'b0}}, a} * {{tvs_pkg::MUL_A_W{1'b0}}, b};
		end
	end

	assign prod = prod_q;

endmodule

// File: design/trilinear_voxel_splat_core.sv
// ----------------------------------------------------------------------------
// trilinear_voxel_splat_core: RGB voxel store with trilinear additive splats
// Splat, clear and read requests run through a sequencer with one shared
// multiplier and one voxel RAM port pair; one result strobe per request.
// ----------------------------------------------------------------------------
// Sequence: a splat visits its eight corners in turn: S_AXIS alone if a corner is
//   outside the cube, S_AXIS, S_WZ, S_CHK if its weight is too small, and then
//   S_MG, S_MB, S_WR if it is written. A read runs S_RD and S_RDW, a clear writes
//   every voxel in S_WIPE, and each request ends in S_FIN, which raises the strobe.
// Throughput: one request at a time; busy is high after acceptance until the strobe.
// Reset: asynchronous, then a clearing pass over all GRID_SIZE^3 voxels (512 at the
//   default size) with busy high; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module trilinear_voxel_splat_core #(
	parameter int GRID_SIZE = tvs_pkg::GRID_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic signed [12:0] point_x,
	input  logic signed [12:0] point_y,
	input  logic signed [12:0] point_z,
	input  logic [11:0]        red_level,
	input  logic [11:0]        green_level,
	input  logic [11:0]        blue_level,
	input  logic [2:0]         read_x,
	input  logic [2:0]         read_y,
	input  logic [2:0]         read_z,
	output logic               done,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic [3:0]         corners_written
);

	localparam int DEPTH  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [6:0]  GRID_W7 = 7'(GRID_SIZE);
	localparam logic [15:0] ROW_16  = 16'(GRID_SIZE);
	localparam logic [15:0] PLANE_16 = 16'(GRID_SIZE * GRID_SIZE);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_WIPE = 11'b000_0000_0010,
		S_AXIS = 11'b000_0000_0100,
		S_WZ   = 11'b000_0000_1000,
		S_CHK  = 11'b000_0001_0000,
		S_MG   = 11'b000_0010_0000,
		S_MB   = 11'b000_0100_0000,
		S_WR   = 11'b000_1000_0000,
		S_RD   = 11'b001_0000_0000,
		S_RDW  = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	tvs_pkg::op_t op_q;
	logic wipe_report_q;
	logic [ADDR_W-1:0] wipe_q;
	logic [2:0] corner_q;
	logic done_q;

	// request payload
	logic signed [4:0] cell_x_q, cell_y_q, cell_z_q;
	logic [7:0] frac_x_q, frac_y_q, frac_z_q;
	logic [11:0] red_q, green_q, blue_q;
	logic [2:0] rd_x_q, rd_y_q, rd_z_q;

	// corner work registers
	logic [ADDR_W-1:0] addr_q;
	logic [tvs_pkg::MUL_A_W-1:0] w_q;
	logic [7:0] sum_r_q, sum_g_q;

	// result registers
	logic [7:0] res_r_q, res_g_q, res_b_q;
	logic [3:0] count_q;

	// shared unit and RAM hookup
	logic mul_en;
	logic [tvs_pkg::MUL_A_W-1:0] mul_a;
	logic [tvs_pkg::MUL_B_W-1:0] mul_b;
	logic [tvs_pkg::MUL_P_W-1:0] prod;
	logic ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [tvs_pkg::VOXEL_W-1:0] ram_wdata, ram_rdata;

	logic accept;
	logic signed [5:0] cx, cy, cz;
	logic [8:0] wx, wy, wz;
	logic in_cube, read_ok, last_corner;
	logic [ADDR_W-1:0] corner_addr, read_addr;
	logic [7:0] sum_b;

	function automatic logic [ADDR_W-1:0] voxel_index(input logic [4:0] x,
		input logic [4:0] y, input logic [4:0] z);
		logic [15:0] idx;
		idx = 16'(x) + ROW_16 * 16'(y) + PLANE_16 * 16'(z);
		return idx[ADDR_W-1:0];
	endfunction

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// corner coordinates and axis weights for the current corner
	assign cx = {cell_x_q[4], cell_x_q} + {5'd0, corner_q[0]};
	assign cy = {cell_y_q[4], cell_y_q} + {5'd0, corner_q[1]};
	assign cz = {cell_z_q[4], cell_z_q} + {5'd0, corner_q[2]};
	assign wx = corner_q[0] ? {1'b0, frac_x_q} : 9'd256 - {1'b0, frac_x_q};
	assign wy = corner_q[1] ? {1'b0, frac_y_q} : 9'd256 - {1'b0, frac_y_q};
	assign wz = corner_q[2] ? {1'b0, frac_z_q} : 9'd256 - {1'b0, frac_z_q};
	assign in_cube = !cx[5] && ({1'b0, cx} < GRID_W7) && !cy[5] &&
		({1'b0, cy} < GRID_W7) && !cz[5] && ({1'b0, cz} < GRID_W7);
	assign corner_addr = voxel_index(cx[4:0], cy[4:0], cz[4:0]);
	assign last_corner = (corner_q == 3'd7);

	// read request range and address
	assign read_ok = ({4'd0, rd_x_q} < GRID_W7) && ({4'd0, rd_y_q} < GRID_W7) &&
		({4'd0, rd_z_q} < GRID_W7);
	assign read_addr = voxel_index({2'b00, rd_x_q}, {2'b00, rd_y_q}, {2'b00, rd_z_q});

	assign sum_b = tvs_pkg::sat_add(ram_rdata[7:0], prod);

	// multiplier operand selection
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_AXIS: begin
				mul_en = 1'b1;
				mul_a  = {16'd0, wx};
				mul_b  = {3'd0, wy};
			end
			S_WZ: begin
				mul_en = 1'b1;
				mul_a  = {8'd0, prod[16:0]};
				mul_b  = {3'd0, wz};
			end
			S_CHK: begin
				mul_en = 1'b1;
				mul_a  = prod[tvs_pkg::MUL_A_W-1:0];
				mul_b  = red_q;
			end
			S_MG: begin
				mul_en = 1'b1;
				mul_a  = w_q;
				mul_b  = green_q;
			end
			S_MB: begin
				mul_en = 1'b1;
				mul_a  = w_q;
				mul_b  = blue_q;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {sum_r_q, sum_g_q, sum_b};
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		case (state_q)
			S_WIPE: begin
				ram_we    = 1'b1;
				ram_waddr = wipe_q;
				ram_wdata = '0;
			end
			S_WR: begin
				ram_we = 1'b1;
			end
			S_WZ: begin
				ram_re = 1'b1;
			end
			S_RD: begin
				ram_re    = read_ok;
				ram_raddr = read_addr;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_x_q <= point_x[12:8];
			cell_y_q <= point_y[12:8];
			cell_z_q <= point_z[12:8];
			frac_x_q <= point_x[7:0];
			frac_y_q <= point_y[7:0];
			frac_z_q <= point_z[7:0];
			red_q    <= red_level;
			green_q  <= green_level;
			blue_q   <= blue_level;
			rd_x_q   <= read_x;
			rd_y_q   <= read_y;
			rd_z_q   <= read_z;
		end
	end

	// per-corner datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_AXIS: begin
				addr_q <= corner_addr;
			end
			S_CHK: begin
				w_q <= prod[tvs_pkg::MUL_A_W-1:0];
			end
			S_MG: begin
				sum_r_q <= tvs_pkg::sat_add(ram_rdata[23:16], prod);
			end
			S_MB: begin
				sum_g_q <= tvs_pkg::sat_add(ram_rdata[15:8], prod);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_WIPE;
			op_q          <= tvs_pkg::OP_NONE;
			wipe_report_q <= 1'b0;
			wipe_q        <= '0;
			corner_q      <= '0;
			done_q        <= 1'b0;
			count_q       <= '0;
			res_r_q       <= '0;
			res_g_q       <= '0;
			res_b_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= tvs_pkg::op_t'(op);
						count_q  <= '0;
						res_r_q  <= '0;
						res_g_q  <= '0;
						res_b_q  <= '0;
						corner_q <= '0;
						wipe_q   <= '0;
						case (tvs_pkg::op_t'(op))
							tvs_pkg::OP_SPLAT: begin
								state_q <= S_AXIS;
							end
							tvs_pkg::OP_CLEAR: begin
								wipe_report_q <= 1'b1;
								state_q       <= S_WIPE;
							end
							tvs_pkg::OP_READ: begin
								state_q <= S_RD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == LAST_ADDR) begin
						wipe_report_q <= 1'b0;
						state_q       <= wipe_report_q ? S_FIN : S_IDLE;
					end
				end
				S_AXIS: begin
					if (in_cube) begin
						state_q <= S_WZ;
					end else if (last_corner) begin
						state_q <= S_FIN;
					end else begin
						corner_q <= corner_q + 3'd1;
					end
				end
				S_WZ: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (prod[tvs_pkg::MUL_A_W-1:0] > tvs_pkg::WEIGHT_FLOOR) begin
						state_q <= S_MG;
					end else if (last_corner) begin
						state_q <= S_FIN;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_AXIS;
					end
				end
				S_MG: begin
					state_q <= S_MB;
				end
				S_MB: begin
					state_q <= S_WR;
				end
				S_WR: begin
					count_q <= count_q + 4'd1;
					if (last_corner) begin
						state_q <= S_FIN;
					end else begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_AXIS;
					end
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					if (read_ok) begin
						res_r_q <= ram_rdata[23:16];
						res_g_q <= ram_rdata[15:8];
						res_b_q <= ram_rdata[7:0];
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign red_out         = res_r_q;
	assign green_out       = res_g_q;
	assign blue_out        = res_b_q;
	assign corners_written = count_q;

	tvs_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	tvs_ram #(
		.WIDTH (tvs_pkg::VOXEL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTHESIS
	// a strobe is never followed by another in the next cycle
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// an accepted request keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after acceptance");

	// store writes only from the clearing walk or a corner update
	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_WIPE || state_q == S_WR))
		else $error("store written outside clear or corner update");

	// only a splat reports updated corners
	a_count_splat_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q != tvs_pkg::OP_SPLAT) |-> (corners_written == 4'd0))
		else $error("corner count on a non-splat request");

	// a splat never reports more than eight corners
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (corners_written <= 4'd8))
		else $error("corner count out of range");
`endif

endmodule

// File: tb/tb_trilinear_voxel_splat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trilinear_voxel_splat_core: self-checking bench for the voxel splat core
// A queue of splat, clear, read and unused-code requests feeds a clocked
// driver. A clocked monitor predicts each accepted request against a shadow
// RGB store and checks every result strobe, field by field, in order.
// ----------------------------------------------------------------------------
module tb_trilinear_voxel_splat_core;
	import tvs_pkg::*;

	localparam int GRID         = GRID_SIZE_DEF;
	localparam int CELLS        = GRID * GRID * GRID;
	localparam int WEIGHT_MIN   = 16777;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		op_t                op;
		logic signed [12:0] px, py, pz;
		logic [11:0]        red, green, blue;
		logic [2:0]         rx, ry, rz;
		int unsigned        gap_pct;
	} splat_req_t;

	typedef struct {
		logic [7:0] red, green, blue;
		logic [3:0] corners;
	} voxel_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy, done;
	logic [7:0] red_out, green_out, blue_out;
	logic [3:0] corners_written;

	splat_req_t cur_req = '{OP_SPLAT, 13'sd0, 13'sd0, 13'sd0, 12'd0, 12'd0, 12'd0,
		3'd0, 3'd0, 3'd0, 0};

	splat_req_t    pending_reqs[$];
	voxel_result_t predicted_results[$];
	logic [7:0]    shadow_red [CELLS];
	logic [7:0]    shadow_green [CELLS];
	logic [7:0]    shadow_blue [CELLS];
	logic          req_taken = 1'b0;
	int            fail_count = 0;
	int            quiet_cycles = 0;

	trilinear_voxel_splat_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (cur_req.op),
		.point_x         (cur_req.px),
		.point_y         (cur_req.py),
		.point_z         (cur_req.pz),
		.red_level       (cur_req.red),
		.green_level     (cur_req.green),
		.blue_level      (cur_req.blue),
		.read_x          (cur_req.rx),
		.read_y          (cur_req.ry),
		.read_z          (cur_req.rz),
		.done            (done),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.corners_written (corners_written)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// round level * weight from 2^-28 units, add, clamp at 255
	function automatic logic [7:0] add_rounded(input logic [7:0] cur,
		input logic [11:0] level, input int wgt);
		longint contrib;
		longint sum;
		contrib = (longint'(level) * wgt + (longint'(1) << 27)) >>> 28;
		sum = longint'(cur) + contrib;
		return (sum > 255) ? 8'd255 : 8'(sum);
	endfunction

	// update the shadow store for one request and return its result
	function automatic voxel_result_t apply_request(input splat_req_t rq);
		voxel_result_t res;
		int base_x, base_y, base_z, fr_x, fr_y, fr_z;
		int cx, cy, cz, wx, wy, wz, wgt, idx, hits;
		res = '{8'd0, 8'd0, 8'd0, 4'd0};
		hits = 0;
		case (rq.op)
			OP_SPLAT: begin
				// floor cell and fraction per axis
				base_x = int'(rq.px) >>> 8;
				base_y = int'(rq.py) >>> 8;
				base_z = int'(rq.pz) >>> 8;
				fr_x = int'(rq.px) - base_x * 256;
				fr_y = int'(rq.py) - base_y * 256;
				fr_z = int'(rq.pz) - base_z * 256;
				for (int dz = 0; dz < 2; dz++) begin
					cz = base_z + dz;
					wz = dz ? fr_z : 256 - fr_z;
					for (int dy = 0; dy < 2; dy++) begin
						cy = base_y + dy;
						wy = dy ? fr_y : 256 - fr_y;
						for (int dx = 0; dx < 2; dx++) begin
							cx = base_x + dx;
							wx = dx ? fr_x : 256 - fr_x;
							wgt = wx * wy * wz;
							// skip corners off the cube or with negligible weight
							if (cx >= 0 && cx < GRID && cy >= 0 && cy < GRID &&
								cz >= 0 && cz < GRID && wgt > WEIGHT_MIN) begin
								idx = cx + GRID * (cy + GRID * cz);
								shadow_red[idx]   = add_rounded(shadow_red[idx], rq.red, wgt);
								shadow_green[idx] = add_rounded(shadow_green[idx], rq.green, wgt);
								shadow_blue[idx]  = add_rounded(shadow_blue[idx], rq.blue, wgt);
								hits++;
							end
						end
					end
				end
				res.corners = 4'(hits);
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					shadow_red[i]   = 8'd0;
					shadow_green[i] = 8'd0;
					shadow_blue[i]  = 8'd0;
				end
			end
			OP_READ: begin
				if (rq.rx < GRID && rq.ry < GRID && rq.rz < GRID) begin
					idx = rq.rx + GRID * (rq.ry + GRID * rq.rz);
					res.red   = shadow_red[idx];
					res.green = shadow_green[idx];
					res.blue  = shadow_blue[idx];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic splat_req_t make_req(input op_t op, input int px, input int py,
		input int pz, input int red, input int green, input int blue, input int rx,
		input int ry, input int rz, input int unsigned gap_pct);
		splat_req_t rq;
		rq.op = op;
		rq.px = 13'(px);
		rq.py = 13'(py);
		rq.pz = 13'(pz);
		rq.red = 12'(red);
		rq.green = 12'(green);
		rq.blue = 12'(blue);
		rq.rx = 3'(rx);
		rq.ry = 3'(ry);
		rq.rz = 3'(rz);
		rq.gap_pct = gap_pct;
		return rq;
	endfunction

	// mostly points near the cube, some anywhere, some on exact grid points
	function automatic int rand_coord();
		int p;
		if ($urandom_range(99) < 85)
			p = int'($urandom_range(2303)) - 256;
		else
			p = int'($urandom_range(8191)) - 4096;
		if ($urandom_range(9) == 0)
			p = p & ~255;
		return p;
	endfunction

	function automatic int rand_level();
		return ($urandom_range(1)) ? int'($urandom_range(4095)) : int'($urandom_range(255));
	endfunction

	function automatic splat_req_t rand_req(input int unsigned gap_pct);
		int pick;
		op_t op;
		pick = $urandom_range(99);
		if (pick < 55)
			op = OP_SPLAT;
		else if (pick < 90)
			op = OP_READ;
		else if (pick < 92)
			op = OP_CLEAR;
		else
			op = OP_NONE;
		return make_req(op, rand_coord(), rand_coord(), rand_coord(), rand_level(),
			rand_level(), rand_level(), $urandom_range(7), $urandom_range(7),
			$urandom_range(7), gap_pct);
	endfunction

	// driver: present the next request at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || req_taken)) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].gap_pct) begin
				cur_req <= pending_reqs.pop_front();
				start   <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check strobed results, then predict the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		voxel_result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			if (done) begin
				if (predicted_results.size() == 0) begin
					$error("result strobe with no request outstanding");
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (red_out !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, red_out);
						fail_count++;
					end
					if (green_out !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, green_out);
						fail_count++;
					end
					if (blue_out !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
						fail_count++;
					end
					if (corners_written !== want.corners) begin
						$error("corners_written: expected %0d, got %0d", want.corners,
							corners_written);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predicted_results.push_back(apply_request(cur_req));
				req_taken <= 1'b1;
			end else begin
				req_taken <= 1'b0;
			end
		end
	end

	// watchdog: cycles with neither an accepted request nor a result
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_trilinear_voxel_splat_core failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_gap [3];
		phase_gap = '{26, 46, 0};
		for (int i = 0; i < CELLS; i++) begin
			shadow_red[i]   = 8'd0;
			shadow_green[i] = 8'd0;
			shadow_blue[i]  = 8'd0;
		end

		// directed: empty read, single-corner saturating splat, cube center
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 256, 512, 768, 4095, 4095, 4095, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 1, 2, 3, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 896, 896, 896, 100, 200, 300, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 4, 4, 4, 26));
		// points fully below and fully above the cube
		pending_reqs.push_back(make_req(OP_SPLAT, -4096, -4096, -4096, 4095, 4095, 4095,
			7, 7, 7, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 4095, 4095, 4095, 4095, 4095, 4095,
			7, 7, 7, 26));
		// upper corners off the far faces, lower corner off the near face
		pending_reqs.push_back(make_req(OP_SPLAT, 1920, 1920, 1920, 2000, 1000, 50, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 7, 7, 7, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, -128, 0, 0, 800, 1600, 3200, 0, 0, 0, 26));
		// corner weights around the drop threshold
		pending_reqs.push_back(make_req(OP_SPLAT, 528, 528, 528, 4095, 16, 1, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 529, 516, 512, 4095, 4095, 4095, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 528, 516, 512, 4095, 4095, 4095, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 3, 2, 2, 26));
		// unused op code with every field at its top value
		pending_reqs.push_back(make_req(OP_NONE, 4095, 4095, 4095, 4095, 4095, 4095,
			7, 7, 7, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 2, 2, 2, 26));
		pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 4, 4, 4, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_SPLAT, 255, 255, 255, 4095, 2048, 8, 0, 0, 0, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 1, 1, 1, 26));
		pending_reqs.push_back(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 26));

		// random requests in three idling phases
		for (int ph = 0; ph < 3; ph++)
			for (int n = 0; n < 510; n++)
				pending_reqs.push_back(rand_req(phase_gap[ph]));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait until every request is sent and every result is checked
		while (pending_reqs.size() != 0 || start || predicted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_trilinear_voxel_splat_core passed");
		else
			$display("tb_trilinear_voxel_splat_core failed");
		$finish;
	end

endmodule
